// ----- rtl/cda_pkg.sv -----
// Shared types, constants and calendar helper functions for the date advance core.
package cda_pkg;

   // Widths fixed by the beat formats.
   localparam int COUNT_W   = 10;
   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_IN_W = 16;
   localparam int KIND_W    = 3;

   // Largest day count a request can ask for is a full count of weeks.
   localparam int DAYS_PER_WEEK = 7;
   localparam int STEP_W  = $clog2(((1 << COUNT_W) - 1) * DAYS_PER_WEEK + 1);

   // Year scaling for the year, decade and century units.
   localparam int SCALE_YEAR    = 1;
   localparam int SCALE_DECADE  = 10;
   localparam int SCALE_CENTURY = 100;
   localparam int MULT_W        = $clog2(SCALE_CENTURY + 1);
   localparam int SCALE_W       = $clog2(((1 << COUNT_W) - 1) * SCALE_CENTURY + 1);

   // The leap rule repeats every 400 years, so the year is tracked modulo 400.
   localparam int LEAP_CYCLE   = 400;
   localparam int LEAP_CENTURY = 100;
   localparam int RES_W        = $clog2(LEAP_CYCLE);
   localparam int REDUCE_STEPS = 8;
   localparam int RED_CNT_W    = $clog2(REDUCE_STEPS);
   localparam int REDUCE_W     = YEAR_IN_W + 1;

   localparam int MONTH_JAN = 1;
   localparam int MONTH_FEB = 2;
   localparam int MONTH_DEC = 12;
   localparam int DAY_FIRST = 1;
   localparam int FEB_LEAP_LEN   = 29;
   localparam int FEB_COMMON_LEN = 28;

   // Unit codes of the request.
   localparam logic [KIND_W-1:0] KIND_DAYS      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WEEKS     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MONTHS    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_YEARS     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DECADES   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CENTURIES = 3'd5;

   localparam logic [DAY_W-1:0] MONTH_LEN_TAB [MONTH_DEC] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_DAYS,
      CLS_MONTHS,
      CLS_YEARS
   } cls_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_REDUCE,
      ST_DAY_RUN,
      ST_MONTH_RUN,
      ST_YEAR_ADD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic idle;
      logic reduce;
      logic day_step;
      logic month_step;
      logic year_add;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic    req_fire;
      cls_type cls;
      logic    reduce_last;
      logic    steps_zero;
      logic    rsp_free;
   } status_type;

   // Leap test on the year taken modulo 400.
   function automatic logic is_leap(input logic [RES_W-1:0] res);
      logic div4;
      logic on_century;
      div4       = (res[1:0] == 2'd0);
      on_century = (res == RES_W'(LEAP_CENTURY)) || (res == RES_W'(2 * LEAP_CENTURY))
                || (res == RES_W'(3 * LEAP_CENTURY));
      return (res == '0) || (div4 && !on_century);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      if (month == MONTH_W'(MONTH_FEB)) begin
         len = leap ? DAY_W'(FEB_LEAP_LEN) : DAY_W'(FEB_COMMON_LEN);
      end else if (month >= MONTH_W'(MONTH_JAN) && month <= MONTH_W'(MONTH_DEC)) begin
         len = MONTH_LEN_TAB[month - MONTH_W'(MONTH_JAN)];
      end else begin
         len = '0;
      end
      return len;
   endfunction

endpackage

// ----- rtl/cda_req_if.sv -----
// Request channel carrying the starting date, unit and count.
interface cda_req_if;
   logic                            valid;
   logic                            ready;
   logic [cda_pkg::KIND_W-1:0]      kind;
   logic [cda_pkg::COUNT_W-1:0]     count;
   logic [cda_pkg::DAY_W-1:0]       start_day;
   logic [cda_pkg::MONTH_W-1:0]     start_month;
   logic [cda_pkg::YEAR_IN_W-1:0]   start_year;

   modport source (output valid, kind, count, start_day, start_month, start_year,
                   input ready);
   modport sink (input valid, kind, count, start_day, start_month, start_year,
                 output ready);
endinterface

// ----- rtl/cda_rsp_if.sv -----
// Response channel carrying the advanced date and its flags.
interface cda_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cda_pkg::DAY_W-1:0]       end_day;
   logic [cda_pkg::MONTH_W-1:0]     end_month;
   logic [cda_pkg::YEAR_IN_W-1:0]   end_year;
   logic                            month_error;
   logic                            year_overflow;

   modport source (output valid, end_day, end_month, end_year, month_error, year_overflow,
                   input ready);
   modport sink (input valid, end_day, end_month, end_year, month_error, year_overflow,
                 output ready);
endinterface

// ----- rtl/cda_ctrl.sv -----
// Sequencing state machine of the date advance core.
module cda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  cda_pkg::status_type   status,
   output cda_pkg::cmd_type      cmd
);

   cda_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         cda_pkg::ST_IDLE: begin
            if (status.req_fire) state_in = cda_pkg::ST_DISPATCH;
         end
         cda_pkg::ST_DISPATCH: begin
            unique case (status.cls) inside
               cda_pkg::CLS_DAYS, cda_pkg::CLS_MONTHS: state_in = cda_pkg::ST_REDUCE;
               cda_pkg::CLS_YEARS:                     state_in = cda_pkg::ST_YEAR_ADD;
               default:                                state_in = cda_pkg::ST_FINISH;
            endcase
         end
         cda_pkg::ST_REDUCE: begin
            if (status.reduce_last) begin
               state_in = (status.cls == cda_pkg::CLS_DAYS) ? cda_pkg::ST_DAY_RUN
                                                            : cda_pkg::ST_MONTH_RUN;
            end
         end
         cda_pkg::ST_DAY_RUN, cda_pkg::ST_MONTH_RUN: begin
            if (status.steps_zero) state_in = cda_pkg::ST_FINISH;
         end
         cda_pkg::ST_YEAR_ADD: begin
            state_in = cda_pkg::ST_FINISH;
         end
         cda_pkg::ST_FINISH: begin
            if (status.rsp_free) state_in = cda_pkg::ST_IDLE;
         end
         default: state_in = cda_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         cda_pkg::ST_IDLE:      cmd.idle       = 1'b1;
         cda_pkg::ST_REDUCE:    cmd.reduce     = 1'b1;
         cda_pkg::ST_DAY_RUN:   cmd.day_step   = !status.steps_zero;
         cda_pkg::ST_MONTH_RUN: cmd.month_step = !status.steps_zero;
         cda_pkg::ST_YEAR_ADD:  cmd.year_add   = 1'b1;
         cda_pkg::ST_FINISH:    cmd.publish    = status.rsp_free;
         default:               cmd            = '0;
      endcase
   end

endmodule

// ----- rtl/cda_datapath.sv -----
// Date registers, year residue tracking, step counter and response register.
module cda_datapath #(
   parameter int MAX_COUNT = 1023,
   parameter int YEAR_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   cda_req_if.sink               req_chan,
   cda_rsp_if.source             rsp_chan,
   input  cda_pkg::cmd_type      cmd,
   output cda_pkg::status_type   status
);

   localparam int LOAD_W = (YEAR_BITS > cda_pkg::YEAR_IN_W) ? YEAR_BITS : cda_pkg::YEAR_IN_W;
   localparam int SUM_W  = ((YEAR_BITS > cda_pkg::SCALE_W) ? YEAR_BITS : cda_pkg::SCALE_W) + 1;
   localparam int SAT_W  = 17;
   localparam logic [YEAR_BITS-1:0] YEAR_TOP = '1;

   logic [cda_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [cda_pkg::COUNT_W-1:0]   count_ff, count_in;
   cda_pkg::cls_type              cls_ff, cls_in;
   logic                          merr_ff, merr_in;
   logic                          ovf_ff, ovf_in;
   logic [cda_pkg::DAY_W-1:0]     day_ff, day_in;
   logic [cda_pkg::MONTH_W-1:0]   month_ff, month_in;
   logic [YEAR_BITS-1:0]          year_ff, year_in;
   logic [cda_pkg::YEAR_IN_W-1:0] rem_ff, rem_in;
   logic [cda_pkg::RED_CNT_W-1:0] red_cnt_ff, red_cnt_in;
   logic [cda_pkg::STEP_W-1:0]    steps_ff, steps_in;
   logic [cda_pkg::DAY_W-1:0]     out_day_ff, out_day_in;
   logic [cda_pkg::MONTH_W-1:0]   out_month_ff, out_month_in;
   logic [cda_pkg::YEAR_IN_W-1:0] out_year_ff, out_year_in;
   logic                          out_merr_ff, out_merr_in;
   logic                          out_ovf_ff, out_ovf_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          load;
   logic [cda_pkg::COUNT_W-1:0]   count_sat;
   logic [LOAD_W-1:0]             year_load;
   logic [cda_pkg::RES_W-1:0]     res;
   logic                          leap;
   logic [cda_pkg::DAY_W-1:0]     cur_len;
   logic [cda_pkg::MONTH_W-1:0]   next_month;
   logic [cda_pkg::DAY_W-1:0]     next_len;
   logic                          year_wrap;
   logic                          year_full;
   logic [YEAR_BITS-1:0]          year_plus;
   logic [cda_pkg::YEAR_IN_W-1:0] res_plus;
   logic [cda_pkg::REDUCE_W-1:0]  red_sub;
   logic [cda_pkg::MULT_W-1:0]    mult;
   logic [cda_pkg::SCALE_W-1:0]   scaled;
   logic [SUM_W-1:0]              year_sum;

   assign load           = req_chan.valid && cmd.idle;
   assign req_chan.ready = cmd.idle;

   assign count_sat = (SAT_W'(req_chan.count) > SAT_W'(MAX_COUNT))
                    ? cda_pkg::COUNT_W'(MAX_COUNT) : req_chan.count;
   assign year_load = (LOAD_W'(req_chan.start_year) > LOAD_W'(YEAR_TOP))
                    ? LOAD_W'(YEAR_TOP) : LOAD_W'(req_chan.start_year);

   assign res        = rem_ff[cda_pkg::RES_W-1:0];
   assign leap       = cda_pkg::is_leap(res);
   assign cur_len    = cda_pkg::month_len(month_ff, leap);
   assign year_wrap  = (month_ff == cda_pkg::MONTH_W'(cda_pkg::MONTH_DEC));
   assign next_month = year_wrap ? cda_pkg::MONTH_W'(cda_pkg::MONTH_JAN)
                                 : month_ff + cda_pkg::MONTH_W'(1);
   // A new year only ever starts in January, whose length does not depend on the
   // leap rule, so the current residue serves for the next month's length.
   assign next_len   = cda_pkg::month_len(next_month, leap);
   assign year_full  = (year_ff == YEAR_TOP);
   assign year_plus  = year_ff + YEAR_BITS'(1);
   assign res_plus   = (res == cda_pkg::RES_W'(cda_pkg::LEAP_CYCLE - 1)) ? '0
                     : cda_pkg::YEAR_IN_W'(res) + cda_pkg::YEAR_IN_W'(1);
   assign red_sub    = cda_pkg::REDUCE_W'(cda_pkg::LEAP_CYCLE) << red_cnt_ff;

   always_comb begin
      case (kind_ff)
         cda_pkg::KIND_YEARS:   mult = cda_pkg::MULT_W'(cda_pkg::SCALE_YEAR);
         cda_pkg::KIND_DECADES: mult = cda_pkg::MULT_W'(cda_pkg::SCALE_DECADE);
         default:               mult = cda_pkg::MULT_W'(cda_pkg::SCALE_CENTURY);
      endcase
   end

   assign scaled   = cda_pkg::SCALE_W'(count_ff) * cda_pkg::SCALE_W'(mult);
   assign year_sum = SUM_W'(year_ff) + SUM_W'(scaled);

   always_comb begin
      kind_in      = kind_ff;
      count_in     = count_ff;
      cls_in       = cls_ff;
      merr_in      = merr_ff;
      ovf_in       = ovf_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      rem_in       = rem_ff;
      red_cnt_in   = red_cnt_ff;
      steps_in     = steps_ff;
      out_day_in   = out_day_ff;
      out_month_in = out_month_ff;
      out_year_in  = out_year_ff;
      out_merr_in  = out_merr_ff;
      out_ovf_in   = out_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (load) begin
         kind_in    = req_chan.kind;
         count_in   = count_sat;
         ovf_in     = 1'b0;
         day_in     = req_chan.start_day;
         month_in   = req_chan.start_month;
         year_in    = YEAR_BITS'(year_load);
         rem_in     = cda_pkg::YEAR_IN_W'(year_load);
         red_cnt_in = cda_pkg::RED_CNT_W'(cda_pkg::REDUCE_STEPS - 1);
         merr_in    = (req_chan.start_month < cda_pkg::MONTH_W'(cda_pkg::MONTH_JAN))
                   || (req_chan.start_month > cda_pkg::MONTH_W'(cda_pkg::MONTH_DEC));
         steps_in   = (req_chan.kind == cda_pkg::KIND_WEEKS)
                    ? cda_pkg::STEP_W'(count_sat) * cda_pkg::STEP_W'(cda_pkg::DAYS_PER_WEEK)
                    : cda_pkg::STEP_W'(count_sat);
         if (merr_in) begin
            cls_in = cda_pkg::CLS_NONE;
         end else begin
            unique case (req_chan.kind) inside
               cda_pkg::KIND_DAYS, cda_pkg::KIND_WEEKS: cls_in = cda_pkg::CLS_DAYS;
               cda_pkg::KIND_MONTHS:                    cls_in = cda_pkg::CLS_MONTHS;
               cda_pkg::KIND_YEARS, cda_pkg::KIND_DECADES, cda_pkg::KIND_CENTURIES:
                                                        cls_in = cda_pkg::CLS_YEARS;
               default:                                 cls_in = cda_pkg::CLS_NONE;
            endcase
         end
      end

      // One restoring step of the year modulo 400 reduction.
      if (cmd.reduce) begin
         if (cda_pkg::REDUCE_W'(rem_ff) >= red_sub) begin
            rem_in = cda_pkg::YEAR_IN_W'(cda_pkg::REDUCE_W'(rem_ff) - red_sub);
         end
         red_cnt_in = red_cnt_ff - cda_pkg::RED_CNT_W'(1);
      end

      if (cmd.day_step || cmd.month_step) begin
         steps_in = steps_ff - cda_pkg::STEP_W'(1);
         if (cmd.day_step && day_ff < cur_len) begin
            day_in = day_ff + cda_pkg::DAY_W'(1);
         end else begin
            if (cmd.day_step) begin
               day_in = cda_pkg::DAY_W'(cda_pkg::DAY_FIRST);
            end else if (day_ff > next_len) begin
               day_in = next_len;
            end
            month_in = next_month;
            if (year_wrap) begin
               if (year_full) begin
                  ovf_in = 1'b1;
               end else begin
                  year_in = year_plus;
                  rem_in  = res_plus;
               end
            end
         end
      end

      if (cmd.year_add) begin
         if (year_sum > SUM_W'(YEAR_TOP)) begin
            year_in = YEAR_TOP;
            ovf_in  = 1'b1;
         end else begin
            year_in = YEAR_BITS'(year_sum);
         end
      end

      if (cmd.publish) begin
         out_day_in   = day_ff;
         out_month_in = month_ff;
         out_year_in  = cda_pkg::YEAR_IN_W'(year_ff);
         out_merr_in  = merr_ff;
         out_ovf_in   = ovf_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      count_ff     <= count_in;
      cls_ff       <= cls_in;
      merr_ff      <= merr_in;
      ovf_ff       <= ovf_in;
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      rem_ff       <= rem_in;
      red_cnt_ff   <= red_cnt_in;
      steps_ff     <= steps_in;
      out_day_ff   <= out_day_in;
      out_month_ff <= out_month_in;
      out_year_ff  <= out_year_in;
      out_merr_ff  <= out_merr_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign status.req_fire    = load;
   assign status.cls         = cls_ff;
   assign status.reduce_last = (red_cnt_ff == '0);
   assign status.steps_zero  = (steps_ff == '0);
   assign status.rsp_free    = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.end_day       = out_day_ff;
   assign rsp_chan.end_month     = out_month_ff;
   assign rsp_chan.end_year      = out_year_ff;
   assign rsp_chan.month_error   = out_merr_ff;
   assign rsp_chan.year_overflow = out_ovf_ff;

endmodule

// ----- rtl/calendar_date_advance_core.sv -----
// Gregorian date advance core: adds days, weeks, months, years, decades or centuries to a date.
// Day and week units advance one day per step (steps = count, or 7 * count for weeks),
// month units one month per step, and year units add the scaled count; a bad month or
// unused unit returns the date unchanged. One request is in work at a time; the next beat
// is taken in the cycle after the response is loaded. The step loop takes one step per cycle.
// Reset is synchronous and active high; it clears the sequencer and the response valid flag.
module calendar_date_advance_core #(
   parameter int MAX_COUNT = 1023,
   parameter int YEAR_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   cda_req_if.sink    req_chan,
   cda_rsp_if.source  rsp_chan
);

   // The controller and the datapath talk only through these two bundles.
   cda_pkg::cmd_type    cmd;
   cda_pkg::status_type status;

   // Each request passes dispatch, then for day and month units an eight-step year
   // modulo 400 reduction (the leap rule repeats every 400 years) and the step loop;
   // year units take one year add, and the response loads once its register is free.
   cda_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath holds the working date, the year residue, the step counter and the
   // response register. The response register lets a finished beat wait downstream
   // while the next request is already being taken and worked on.
   cda_datapath #(
      .MAX_COUNT (MAX_COUNT),
      .YEAR_BITS (YEAR_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .status   (status)
   );

   // A loaded response always shows up as a valid beat in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_chan.valid)
      else $error("published response did not appear on the response channel");

   // A bad month never reports a year overflow, since the date is returned unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.month_error) |-> !rsp_chan.year_overflow)
      else $error("month error beat also flags a year overflow");

   // Without a month error the response month is a real month.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.month_error) |->
         (rsp_chan.end_month >= 4'd1 && rsp_chan.end_month <= 4'd12))
      else $error("response month out of range");

   // The step loop never advances once its counter has run out.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.day_step || cmd.month_step) |-> !status.steps_zero)
      else $error("date step issued with no steps left");

endmodule
